// ===== src/command_line_tokenizer_assert.svh =====
// assertion helpers shared by the tokenizer modules
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CLTOK_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define CLTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cltok_pkg.sv =====
package cltok_pkg;

   localparam int MaxLine = 512;
   localparam int ObufDepth = 4;

   // backslash count saturates at one less than the line size, capped by the 9-bit counter
   localparam logic [8:0] BsCap = (MaxLine - 1 > 511) ? 9'd511 : 9'(MaxLine - 1);
   localparam logic [8:0] ArgsCap = 9'd511;
   localparam logic [1:0] QuoteLiteral = 2'd3;

   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChNul    = 8'h00;

   typedef enum logic [2:0] {
      PH_START       = 3'd0,
      PH_PATH_QUOTED = 3'd1,
      PH_PATH_PLAIN  = 3'd2,
      PH_BETWEEN     = 3'd3,
      PH_IN_ARG      = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTES    = 2'd0,
      KIND_ARG_END  = 2'd1,
      KIND_LINE_END = 2'd2,
      KIND_EMPTY    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_value;
      logic [8:0] repeat_res;
      logic [8:0] arg_total;
      logic       last;
   } result_type;

   // results of one input word, slot 0 first
   typedef struct packed {
      logic [1:0]       cnt;
      result_type [2:0] res;
   } push_type;

   function automatic result_type mk_res(kind_type k, logic [7:0] b, logic [8:0] r,
                                         logic [8:0] t);
      result_type x;
      x.kind       = k;
      x.byte_value = b;
      x.repeat_res = r;
      x.arg_total  = t;
      x.last       = 1'b0;
      return x;
   endfunction

endpackage

// ===== src/cltok_step.sv =====
`include "command_line_tokenizer_assert.svh"

module cltok_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           ch,
   output cltok_pkg::push_type  push_data
);

   cltok_pkg::phase_type phase_ff, phase_in;
   logic [1:0] ql_ff, ql_in;
   logic [8:0] bs_ff, bs_in;
   logic       run_ff, run_in;
   logic [8:0] args_ff, args_in;

   logic is_quote, is_bslash, is_ws, is_nul, enter;
   logic [1:0] q_eff, q_inc, q_rel;
   logic [8:0] bs_eff, args_eff;
   logic       run_eff;

   cltok_pkg::result_type [2:0] res_v;
   logic [1:0] n_v;

   assign is_quote  = (ch == cltok_pkg::ChQuote);
   assign is_bslash = (ch == cltok_pkg::ChBslash);
   assign is_ws     = (ch == cltok_pkg::ChSpace) || (ch == cltok_pkg::ChTab);
   assign is_nul    = (ch == cltok_pkg::ChNul);

   // first byte after whitespace opens a new argument with fresh quote state
   assign enter    = (phase_ff == cltok_pkg::PH_BETWEEN);
   assign q_eff    = enter ? 2'd0 : ql_ff;
   assign bs_eff   = enter ? 9'd0 : bs_ff;
   assign run_eff  = enter ? 1'b0 : run_ff;
   assign args_eff = (enter && args_ff < cltok_pkg::ArgsCap) ? args_ff + 9'd1 : args_ff;
   assign q_inc    = q_eff + 2'd1;
   assign q_rel    = (run_eff && q_eff == 2'd2) ? 2'd0 : q_eff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      ql_in    = ql_ff;
      bs_in    = bs_ff;
      run_in   = run_ff;
      args_in  = args_ff;
      if (accept) begin
         case (phase_ff)
            cltok_pkg::PH_PATH_QUOTED, cltok_pkg::PH_PATH_PLAIN: begin
               if ((phase_ff == cltok_pkg::PH_PATH_QUOTED && is_quote) ||
                   (phase_ff == cltok_pkg::PH_PATH_PLAIN && is_ws)) begin
                  phase_in = cltok_pkg::PH_BETWEEN;
               end else if (is_nul) begin
                  phase_in = cltok_pkg::PH_START;
                  ql_in    = 2'd0;
                  bs_in    = 9'd0;
                  run_in   = 1'b0;
                  args_in  = 9'd0;
               end
            end
            cltok_pkg::PH_BETWEEN, cltok_pkg::PH_IN_ARG: begin
               if (enter && is_ws) begin
                  phase_in = phase_ff;
               end else if (enter && is_nul) begin
                  phase_in = cltok_pkg::PH_START;
                  ql_in    = 2'd0;
                  bs_in    = 9'd0;
                  run_in   = 1'b0;
                  args_in  = 9'd0;
               end else begin
                  phase_in = cltok_pkg::PH_IN_ARG;
                  ql_in    = q_eff;
                  bs_in    = bs_eff;
                  run_in   = run_eff;
                  args_in  = args_eff;
                  if (is_quote) begin
                     if (run_eff) begin
                        ql_in = (q_inc == cltok_pkg::QuoteLiteral) ? 2'd0 : q_inc;
                     end else begin
                        if (!bs_eff[0]) ql_in = q_inc;
                        bs_in  = 9'd0;
                        run_in = 1'b1;
                     end
                  end else begin
                     ql_in  = q_rel;
                     run_in = 1'b0;
                     if (is_bslash) begin
                        if (bs_eff < cltok_pkg::BsCap) bs_in = bs_eff + 9'd1;
                     end else if (is_nul) begin
                        phase_in = cltok_pkg::PH_START;
                        ql_in    = 2'd0;
                        bs_in    = 9'd0;
                        args_in  = 9'd0;
                     end else begin
                        bs_in = 9'd0;
                        if (is_ws && q_rel == 2'd0) phase_in = cltok_pkg::PH_BETWEEN;
                     end
                  end
               end
            end
            default: begin
               ql_in  = 2'd0;
               bs_in  = 9'd0;
               run_in = 1'b0;
               if (is_nul) begin
                  phase_in = cltok_pkg::PH_START;
                  args_in  = 9'd0;
               end else begin
                  args_in = 9'd1;
                  if (is_quote)   phase_in = cltok_pkg::PH_PATH_QUOTED;
                  else if (is_ws) phase_in = cltok_pkg::PH_BETWEEN;
                  else            phase_in = cltok_pkg::PH_PATH_PLAIN;
               end
            end
         endcase
      end
   end

   // result list for the current byte
   always_comb begin
      res_v = '0;
      n_v   = 2'd0;
      case (phase_ff)
         cltok_pkg::PH_PATH_QUOTED, cltok_pkg::PH_PATH_PLAIN: begin
            if ((phase_ff == cltok_pkg::PH_PATH_QUOTED && is_quote) ||
                (phase_ff == cltok_pkg::PH_PATH_PLAIN && is_ws)) begin
               res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_ARG_END, 8'd0, 9'd0, args_ff);
               n_v = n_v + 2'd1;
            end else if (is_nul) begin
               res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_ARG_END, 8'd0, 9'd0, args_ff);
               n_v = n_v + 2'd1;
               res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_LINE_END, 8'd0, 9'd0, args_ff);
               n_v = n_v + 2'd1;
            end else begin
               res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_BYTES, ch, 9'd1, 9'd0);
               n_v = n_v + 2'd1;
            end
         end
         cltok_pkg::PH_BETWEEN, cltok_pkg::PH_IN_ARG: begin
            if (enter && is_ws) begin
               n_v = 2'd0;
            end else if (enter && is_nul) begin
               res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_LINE_END, 8'd0, 9'd0, args_ff);
               n_v = n_v + 2'd1;
            end else if (is_quote) begin
               if (run_eff) begin
                  if (q_inc == cltok_pkg::QuoteLiteral) begin
                     res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_BYTES, cltok_pkg::ChQuote,
                                                    9'd1, 9'd0);
                     n_v = n_v + 2'd1;
                  end
               end else begin
                  // half of the held backslashes survive before a quote
                  if (bs_eff[8:1] != 8'd0) begin
                     res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_BYTES, cltok_pkg::ChBslash,
                                                    {1'b0, bs_eff[8:1]}, 9'd0);
                     n_v = n_v + 2'd1;
                  end
                  if (bs_eff[0]) begin
                     res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_BYTES, cltok_pkg::ChQuote,
                                                    9'd1, 9'd0);
                     n_v = n_v + 2'd1;
                  end
               end
            end else if (!is_bslash) begin
               if (bs_eff != 9'd0) begin
                  res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_BYTES, cltok_pkg::ChBslash,
                                                 bs_eff, 9'd0);
                  n_v = n_v + 2'd1;
               end
               if (is_nul) begin
                  res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_ARG_END, 8'd0, 9'd0, args_eff);
                  n_v = n_v + 2'd1;
                  res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_LINE_END, 8'd0, 9'd0, args_eff);
                  n_v = n_v + 2'd1;
               end else if (is_ws && q_rel == 2'd0) begin
                  res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_ARG_END, 8'd0, 9'd0, args_eff);
                  n_v = n_v + 2'd1;
               end else begin
                  res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_BYTES, ch, 9'd1, 9'd0);
                  n_v = n_v + 2'd1;
               end
            end
         end
         default: begin
            if (is_nul) begin
               res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_EMPTY, 8'd0, 9'd0, 9'd0);
               n_v = n_v + 2'd1;
            end else if (is_ws) begin
               res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_ARG_END, 8'd0, 9'd0, 9'd1);
               n_v = n_v + 2'd1;
            end else if (!is_quote) begin
               res_v[n_v] = cltok_pkg::mk_res(cltok_pkg::KIND_BYTES, ch, 9'd1, 9'd0);
               n_v = n_v + 2'd1;
            end
         end
      endcase
      if (n_v != 2'd0) res_v[n_v - 2'd1].last = 1'b1;
   end

   assign push_data.cnt = n_v;
   assign push_data.res = res_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cltok_pkg::PH_START;
         ql_ff    <= 2'd0;
         bs_ff    <= 9'd0;
         run_ff   <= 1'b0;
         args_ff  <= 9'd0;
      end else begin
         phase_ff <= phase_in;
         ql_ff    <= ql_in;
         bs_ff    <= bs_in;
         run_ff   <= run_in;
         args_ff  <= args_in;
      end
   end

   `CLTOK_ASSERT_NEXT(a_line_end_clears, accept && is_nul, phase_ff == cltok_pkg::PH_START && args_ff == 9'd0 && bs_ff == 9'd0, "line end did not return to start of line")

endmodule

// ===== src/cltok_obuf.sv =====
`include "command_line_tokenizer_assert.svh"

module cltok_obuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cltok_pkg::push_type   push_data,
   input  logic                  pop,
   output cltok_pkg::result_type head,
   output logic                  valid,
   output logic                  ready
);

   cltok_pkg::result_type ent_ff [cltok_pkg::ObufDepth];
   cltok_pkg::result_type ent_in [cltok_pkg::ObufDepth];
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] base;

   // shift out the head, then append the new words behind what remains
   always_comb begin
      for (int i = 0; i < cltok_pkg::ObufDepth - 1; i++) begin
         ent_in[i] = pop ? ent_ff[i + 1] : ent_ff[i];
      end
      ent_in[cltok_pkg::ObufDepth - 1] = ent_ff[cltok_pkg::ObufDepth - 1];
      base = 2'(cnt_ff - {2'b00, pop});
      if (push) begin
         for (int j = 0; j < 3; j++) begin
            if (2'(j) < push_data.cnt) ent_in[2'(base + 2'(j))] = push_data.res[j];
         end
      end
      cnt_in = cnt_ff - {2'b00, pop} + (push ? {1'b0, push_data.cnt} : 3'd0);
   end

   assign head  = ent_ff[0];
   assign valid = (cnt_ff != 3'd0);
   assign ready = (cnt_ff <= 3'd1);

   always_ff @(posedge clock) begin
      for (int i = 0; i < cltok_pkg::ObufDepth; i++) ent_ff[i] <= ent_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 3'd0;
      else       cnt_ff <= cnt_in;
   end

   `CLTOK_ASSERT(a_push_room, push, cnt_ff <= 3'd1, "push with too little room")
   `CLTOK_ASSERT(a_cnt_range, 1'b1, cnt_ff <= 3'(cltok_pkg::ObufDepth), "word count out of range")
   `CLTOK_ASSERT_NEXT(a_push_shows, push && push_data.cnt != 2'd0, valid, "pushed words not shown")

endmodule

// ===== src/command_line_tokenizer.sv =====
// command_line_tokenizer: one command-line byte per input word, argument events out
// output: the first result word of a byte is registered in the result queue and is valid
//   in the cycle after the byte is accepted, behind at most one word still waiting there
// throughput: 1 byte per cycle while each byte gives at most one word and rsp_tready is
//   high; a byte that gives 2 or 3 words holds req_tready low until at most one word is
//   left in the 4-entry result queue
// reset: synchronous, active high; start of line, zero backslashes, zero arguments,
//   result queue empty
module command_line_tokenizer (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] kind, [9:2] byte_value, [18:10] repeat_res,
                                    // [27:19] arg_total, [31:28] zero
   output logic        rsp_tlast    // final word caused by one input byte
);

   logic                  accept;
   logic                  pop;
   cltok_pkg::push_type   push_data;
   cltok_pkg::result_type head;

   // byte taken only when the queue can absorb a worst-case three-word burst
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   // parser state and the combinational result list for this byte
   cltok_step u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ch        (req_tdata),
      .push_data (push_data)
   );

   // registered result queue, decouples the two channels
   cltok_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .valid     (rsp_tvalid),
      .ready     (req_tready)
   );

   assign rsp_tdata = {4'b0000, head.arg_total, head.repeat_res, head.byte_value, head.kind};
   assign rsp_tlast = head.last;

endmodule

// ===== verif/tokenizer_checker.sv =====
module tokenizer_checker
   import cltok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [1:0] kind, [9:2] byte_value, [18:10] repeat_res,
                                    // [27:19] arg_total, [31:28] zero
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          pending_words
);

   // tokenizer state as predicted
   phase_type  line_phase;
   logic [1:0] quote_count;
   logic [8:0] held_bslashes;
   logic       quote_run;
   logic [8:0] arg_count;

   result_type byte_events[$];     // words caused by the byte being predicted
   result_type expected_words[$];

   function void emit(kind_type k, logic [7:0] b, logic [8:0] r, logic [8:0] t);
      result_type w;
      if (byte_events.size() >= 3) return;
      w.kind       = k;
      w.byte_value = b;
      w.repeat_res = r;
      w.arg_total  = t;
      w.last       = 1'b0;
      byte_events.insert(byte_events.size(), w);
   endfunction

   function void clear_line();
      line_phase    = PH_START;
      quote_count   = 2'd0;
      held_bslashes = 9'd0;
      quote_run     = 1'b0;
      arg_count     = 9'd0;
   endfunction

   function bit is_blank(logic [7:0] c);
      return c == ChSpace || c == ChTab;
   endfunction

   function void flush_held();
      if (held_bslashes != 9'd0) emit(KIND_BYTES, ChBslash, held_bslashes, 9'd0);
      held_bslashes = 9'd0;
   endfunction

   function void close_line();
      emit(KIND_ARG_END, 8'd0, 9'd0, arg_count);
      emit(KIND_LINE_END, 8'd0, 9'd0, arg_count);
      clear_line();
   endfunction

   // one byte inside a later argument: escapes and quote counting
   function void arg_char(logic [7:0] ch);
      logic [8:0] half;
      if (ch == ChQuote) begin
         if (quote_run) begin
            quote_count = quote_count + 2'd1;
            if (quote_count == QuoteLiteral) begin
               emit(KIND_BYTES, ChQuote, 9'd1, 9'd0);
               quote_count = 2'd0;
            end
         end else begin
            half = held_bslashes >> 1;
            if (half != 9'd0) emit(KIND_BYTES, ChBslash, half, 9'd0);
            if (!held_bslashes[0]) quote_count = quote_count + 2'd1;
            else emit(KIND_BYTES, ChQuote, 9'd1, 9'd0);
            held_bslashes = 9'd0;
            quote_run     = 1'b1;
         end
         return;
      end
      if (quote_run) begin
         if (quote_count == 2'd2) quote_count = 2'd0;
         quote_run = 1'b0;
      end
      if (ch == ChBslash) begin
         if (held_bslashes < BsCap) held_bslashes = held_bslashes + 9'd1;
         return;
      end
      if (ch == ChNul) begin
         flush_held();
         close_line();
         return;
      end
      flush_held();
      if (is_blank(ch) && quote_count == 2'd0) begin
         emit(KIND_ARG_END, 8'd0, 9'd0, arg_count);
         line_phase = PH_BETWEEN;
         return;
      end
      emit(KIND_BYTES, ch, 9'd1, 9'd0);
   endfunction

   function void tokenize_byte(logic [7:0] ch);
      byte_events.delete();
      case (line_phase)
         PH_PATH_QUOTED: begin
            if (ch == ChQuote) begin
               emit(KIND_ARG_END, 8'd0, 9'd0, arg_count);
               line_phase = PH_BETWEEN;
            end else if (ch == ChNul) close_line();
            else emit(KIND_BYTES, ch, 9'd1, 9'd0);
         end
         PH_PATH_PLAIN: begin
            if (is_blank(ch)) begin
               emit(KIND_ARG_END, 8'd0, 9'd0, arg_count);
               line_phase = PH_BETWEEN;
            end else if (ch == ChNul) close_line();
            else emit(KIND_BYTES, ch, 9'd1, 9'd0);
         end
         PH_BETWEEN: begin
            if (ch == ChNul) begin
               emit(KIND_LINE_END, 8'd0, 9'd0, arg_count);
               clear_line();
            end else if (!is_blank(ch)) begin
               if (arg_count < ArgsCap) arg_count = arg_count + 9'd1;
               line_phase    = PH_IN_ARG;
               quote_count   = 2'd0;
               held_bslashes = 9'd0;
               quote_run     = 1'b0;
               arg_char(ch);
            end
         end
         PH_IN_ARG: arg_char(ch);
         default: begin
            clear_line();
            if (ch == ChNul) emit(KIND_EMPTY, 8'd0, 9'd0, 9'd0);
            else begin
               arg_count = 9'd1;
               if (ch == ChQuote) line_phase = PH_PATH_QUOTED;
               else if (is_blank(ch)) begin
                  emit(KIND_ARG_END, 8'd0, 9'd0, arg_count);
                  line_phase = PH_BETWEEN;
               end else begin
                  emit(KIND_BYTES, ch, 9'd1, 9'd0);
                  line_phase = PH_PATH_PLAIN;
               end
            end
         end
      endcase
      if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
      foreach (byte_events[i]) expected_words.insert(expected_words.size(), byte_events[i]);
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_line();
         expected_words.delete();
         mismatch_count <= 0;
      end else begin
         if (req_tvalid && req_tready) tokenize_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got %h last %0d",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[1:0] != want.kind || rsp_tdata[9:2] != want.byte_value ||
                   rsp_tdata[18:10] != want.repeat_res ||
                   rsp_tdata[27:19] != want.arg_total || rsp_tdata[31:28] != 4'd0 ||
                   rsp_tlast != want.last) begin
                  $display("%0t: result mismatch, expected kind %0d byte %02h rep %0d",
                           $time, want.kind, want.byte_value, want.repeat_res,
                           " total %0d last %0d pad 0, got kind %0d byte %02h rep %0d",
                           want.arg_total, want.last, rsp_tdata[1:0], rsp_tdata[9:2],
                           rsp_tdata[18:10], " total %0d last %0d pad %h",
                           rsp_tdata[27:19], rsp_tlast, rsp_tdata[31:28]);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import cltok_pkg::*;

   // no acceptance on either channel for this many cycles means a hang
   localparam int QuietLimit  = 2000;
   // length of the forced receiver hold-off that backs the block up
   localparam int HoldCycles  = 150;
   // random input words per idling phase
   localparam int PhaseWords  = 55;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;  // [7:0] ch
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [1:0] kind, [9:2] byte_value, [18:10] repeat_res,
                                    // [27:19] arg_total, [31:28] zero
   logic        rsp_tlast;

   int mismatch_count;
   int pending_words;

   // idling knobs, in percent; written by the stimulus process only
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   // each increment asks the receiver process for one long hold-off
   int hold_requests      = 0;
   int words_sent         = 0;
   int quiet_cycles       = 0;

   command_line_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // predicts every result word and compares it as it leaves the block
   tokenizer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // offer one byte, with random idle cycles first, and hold it until accepted;
   // tvalid stays high on return so back-to-back words need no extra edge
   task automatic send_char(input logic [7:0] ch);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // text bytes followed by the terminating zero
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(ChNul);
   endtask

   // stop offering and wait until every predicted word has come out;
   // the first edge lets the checker count the word accepted last
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   // byte mix biased toward the characters that steer the parser
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 11))
         0, 1:    return ChQuote;
         2, 3:    return ChBslash;
         4, 5:    return ChSpace;
         6:       return ChTab;
         7:       return 8'($urandom_range(1, 255));
         default: return 8'($urandom_range(97, 122));
      endcase
   endfunction

   // mostly well-formed lines with random content, some raw noise
   // where zeros can fall anywhere
   task automatic send_random_line();
      int n;
      n = $urandom_range(1, 14);
      if ($urandom_range(0, 7) == 0) begin
         repeat (n) send_char(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 2) == 0) send_char(ChQuote);   // quoted path
         repeat (n) send_char(pick_char());
         send_char(ChNul);
      end
   endtask

   // receiver: random stalls per the current knob, or a long hold-off on request
   initial begin
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles - 1) @(posedge clock);
            holds_done++;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int send_idle[4];
      int recv_stall[4];
      int phase_start;
      // no idling, sender idle, receiver stalling, both
      send_idle  = '{0, 75, 0, 36};
      recv_stall = '{0, 0, 75, 36};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct    = send_idle[p];
         receiver_stall_pct = recv_stall[p];
         if (p == 0) begin
            // empty line: a zero first byte gives an empty-line word
            send_char(ChNul);
            // quoted path holding a space, then one plain argument
            send_text("\"a b\" x");
            // tab as the first byte ends an empty path at once
            send_text("\t");
            // plain path, then odd backslashes before a quote, a run of three
            // quotes, even backslashes before a quote, a high byte, and a
            // backslash still held when the line ends
            send_text("p\t\\\\\\\"\"\"\"\\\\\"\377\\");
            drain_results();

            // receiver holds off while bytes keep coming so the block backs up
            hold_requests++;
            repeat (4) send_random_line();
            // sender pauses until everything has come out
            drain_results();
         end
         phase_start = words_sent;
         while (words_sent - phase_start < PhaseWords) send_random_line();
         drain_results();
      end

      // nothing pending; give the block time to show any stray word
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/cltok_pkg.sv
src/cltok_step.sv
src/cltok_obuf.sv
src/command_line_tokenizer.sv
verif/tokenizer_checker.sv
verif/testbench.sv
